// ===== rtl/vard_pkg.sv =====
// ----------------------------------------------------------------------------
// vard_pkg
// shared types and constants of the record deframer
// ----------------------------------------------------------------------------
package vard_pkg;

  localparam int FRAME_ADDR_BITS_DEF = 25;
  localparam int LINE_BYTES_BITS_DEF = 14;
  localparam int LINE_COUNT_BITS_DEF = 12;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 25;
  localparam int KIND_W     = 3;
  localparam int CNT_W      = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LINE_LEN   = 3'd0,
    REG_STRIDE     = 3'd1,
    REG_HEIGHT     = 3'd2,
    REG_FRAME_SIZE = 3'd3,
    REG_INTERLACE  = 3'd4,
    REG_HALTED     = 3'd5
  } reg_idx_t;

  typedef enum logic [KIND_W-1:0] {
    K_VIDEO  = 3'd0,
    K_AUDIO  = 3'd1,
    K_ABORT  = 3'd2,
    K_START  = 3'd3,
    K_CLEAR  = 3'd4,
    K_FINISH = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    ST_HDR   = 2'd0,
    ST_LINE  = 2'd1,
    ST_AUDIO = 2'd2,
    ST_SKIP  = 2'd3
  } parse_t;

  localparam logic [7:0] BYTE_SYNC = 8'hff;
  localparam logic [7:0] BYTE_ZERO = 8'h00;
  localparam logic [7:0] BIT_V     = 8'h20;
  localparam logic [7:0] BIT_ONE   = 8'h80;

  function automatic logic code_ok(input logic [7:0] xy);
    logic f, v, h;
    f = xy[6];
    v = xy[5];
    h = xy[4];
    return ((xy & BIT_ONE) != BYTE_ZERO) && (xy[3] == (v ^ h)) && (xy[2] == (f ^ h))
      && (xy[1] == (f ^ v)) && (xy[0] == (f ^ v ^ h));
  endfunction

endpackage

// ===== rtl/vard_front.sv =====
// ----------------------------------------------------------------------------
// vard_front
// header gathering, marker decode and frame tracking; emits up to three
// result beats per byte as one packed group
// ----------------------------------------------------------------------------
module vard_front #(
  parameter int FRAME_ADDR_BITS = vard_pkg::FRAME_ADDR_BITS_DEF,
  parameter int LINE_BYTES_BITS = vard_pkg::LINE_BYTES_BITS_DEF,
  parameter int LINE_COUNT_BITS = vard_pkg::LINE_COUNT_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic [7:0]                 in_byte,
  input  logic [LINE_BYTES_BITS-1:0] line_len,
  input  logic [LINE_BYTES_BITS:0]   stride,
  input  logic [LINE_COUNT_BITS-1:0] height,
  input  logic [FRAME_ADDR_BITS-1:0] size_lim,
  input  logic                       interlaced,
  output logic                       grp_valid,
  output logic [1:0]                 grp_cnt,
  output logic [2:0][vard_pkg::KIND_W-1:0] grp_kind,
  output logic [FRAME_ADDR_BITS-1:0] grp_addr,
  output logic [7:0]                 grp_data,
  output logic                       grp_field,
  output logic [vard_pkg::CNT_W-1:0] grp_perr,
  output logic [vard_pkg::CNT_W-1:0] grp_resync
);
  import vard_pkg::*;

  parse_t                     stage_r, stage_nxt;
  logic [23:0]                hdr_r, hdr_nxt;
  logic [1:0]                 hcnt_r, hcnt_nxt;
  logic [LINE_BYTES_BITS+1:0] rem_r, rem_nxt;
  logic [LINE_BYTES_BITS-1:0] off_r, off_nxt;
  logic [FRAME_ADDR_BITS-1:0] base_r, base_nxt;
  logic [LINE_COUNT_BITS-1:0] done_r, done_nxt;
  logic blank_r, blank_nxt, field_r, field_nxt, started_r, started_nxt;
  logic clrp_r, clrp_nxt;
  logic [CNT_W-1:0] perr_r, perr_nxt, rsy_r, rsy_nxt;

  logic [1:0]                 cnt;
  logic [2:0][KIND_W-1:0]     kinds;
  logic [FRAME_ADDR_BITS-1:0] addr;
  logic [7:0]                 data;
  logic [FRAME_ADDR_BITS:0]   sum_addr, sum_base;
  logic                       blank, f;

  assign sum_addr = {1'b0, base_r} + {{(FRAME_ADDR_BITS-LINE_BYTES_BITS+1){1'b0}}, off_r};
  assign sum_base = {1'b0, base_r} + {{(FRAME_ADDR_BITS-LINE_BYTES_BITS){1'b0}}, stride};
  assign blank = (in_byte & BIT_V) != BYTE_ZERO;
  assign f = in_byte[6];

  always_comb begin
    stage_nxt = stage_r; hdr_nxt = hdr_r; hcnt_nxt = hcnt_r; rem_nxt = rem_r;
    off_nxt = off_r; base_nxt = base_r; done_nxt = done_r; blank_nxt = blank_r;
    field_nxt = field_r; started_nxt = started_r; clrp_nxt = clrp_r;
    perr_nxt = perr_r; rsy_nxt = rsy_r;
    cnt = 2'd0; kinds = '0; addr = '0; data = '0;
    case (stage_r)
      ST_HDR: begin
        if (hcnt_r != 2'd3) begin
          hdr_nxt = {hdr_r[15:0], in_byte};
          hcnt_nxt = hcnt_r + 2'd1;
        end else begin
          hcnt_nxt = 2'd0;
          if (hdr_r[23:16] != BYTE_SYNC || hdr_r[15:8] != BYTE_ZERO ||
              (hdr_r[7:0] != BYTE_SYNC && hdr_r[7:0] != BYTE_ZERO)) begin
            if (rsy_r != '1) rsy_nxt = rsy_r + 1'b1;
          end else if (hdr_r[7:0] == BYTE_SYNC) begin
            rem_nxt = {{(LINE_BYTES_BITS-8){1'b0}}, in_byte, 2'b00};
            stage_nxt = (in_byte == BYTE_ZERO) ? ST_HDR : ST_AUDIO;
          end else begin
            if (!code_ok(in_byte) && perr_r != '1) perr_nxt = perr_r + 1'b1;
            if (!blank && blank_r) begin
              blank_nxt = 1'b0;
              field_nxt = f;
              if (!interlaced || !f) begin
                if (started_r) begin
                  kinds[cnt] = K_ABORT; cnt = cnt + 2'd1;
                end
                kinds[cnt] = K_START; cnt = cnt + 2'd1;
                if (interlaced && (clrp_r || started_r)) begin
                  kinds[cnt] = K_CLEAR; cnt = cnt + 2'd1;
                  clrp_nxt = 1'b0;
                end else if (started_r) begin
                  clrp_nxt = 1'b1;
                end
                done_nxt = '0;
                started_nxt = 1'b1;
              end
              base_nxt = (interlaced && f) ?
                {{(FRAME_ADDR_BITS-LINE_BYTES_BITS){1'b0}}, line_len} : '0;
            end else if (blank && !blank_r) begin
              blank_nxt = 1'b1;
              if (started_r && done_r == height) begin
                kinds[0] = K_FINISH; cnt = 2'd1;
              end else if (started_r && (!interlaced || f)) begin
                kinds[0] = K_ABORT; cnt = 2'd1;
                clrp_nxt = 1'b1;
              end
            end
            rem_nxt = {2'b00, line_len};
            off_nxt = '0;
            if (line_len == '0) stage_nxt = ST_HDR;
            else stage_nxt = blank ? ST_SKIP : ST_LINE;
          end
        end
      end
      ST_LINE: begin
        if (sum_addr < {1'b0, size_lim}) begin
          kinds[0] = K_VIDEO; cnt = 2'd1;
          addr = sum_addr[FRAME_ADDR_BITS-1:0];
          data = in_byte;
        end
        off_nxt = off_r + 1'b1;
        rem_nxt = rem_r - 1'b1;
        if (rem_r == 1) begin
          base_nxt = sum_base[FRAME_ADDR_BITS] ? '1 : sum_base[FRAME_ADDR_BITS-1:0];
          if (done_r != '1) done_nxt = done_r + 1'b1;
          stage_nxt = ST_HDR;
        end
      end
      ST_AUDIO: begin
        kinds[0] = K_AUDIO; cnt = 2'd1; data = in_byte;
        rem_nxt = rem_r - 1'b1;
        if (rem_r == 1) stage_nxt = ST_HDR;
      end
      default: begin
        rem_nxt = rem_r - 1'b1;
        if (rem_r == 1) stage_nxt = ST_HDR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r <= ST_HDR; hdr_r <= '0; hcnt_r <= '0; rem_r <= '0; off_r <= '0;
      base_r <= '0; done_r <= '0; blank_r <= 1'b1; field_r <= 1'b0;
      started_r <= 1'b0; clrp_r <= 1'b1; perr_r <= '0; rsy_r <= '0;
      grp_valid <= 1'b0;
    end else begin
      grp_valid <= in_valid && (cnt != 2'd0);
      if (in_valid) begin
        stage_r <= stage_nxt; hdr_r <= hdr_nxt; hcnt_r <= hcnt_nxt; rem_r <= rem_nxt;
        off_r <= off_nxt; base_r <= base_nxt; done_r <= done_nxt;
        blank_r <= blank_nxt; field_r <= field_nxt; started_r <= started_nxt;
        clrp_r <= clrp_nxt; perr_r <= perr_nxt; rsy_r <= rsy_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    grp_cnt <= cnt; grp_kind <= kinds; grp_addr <= addr; grp_data <= data;
    grp_field <= field_nxt; grp_perr <= perr_nxt; grp_resync <= rsy_nxt;
  end

endmodule

// ===== rtl/vard_back.sv =====
// ----------------------------------------------------------------------------
// vard_back
// group queue and unpacker: stores result groups and hands out one beat
// per pop
// ----------------------------------------------------------------------------
module vard_back #(
  parameter int FRAME_ADDR_BITS = vard_pkg::FRAME_ADDR_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       grp_valid,
  input  logic [1:0]                 grp_cnt,
  input  logic [2:0][vard_pkg::KIND_W-1:0] grp_kind,
  input  logic [FRAME_ADDR_BITS-1:0] grp_addr,
  input  logic [7:0]                 grp_data,
  input  logic                       grp_field,
  input  logic [vard_pkg::CNT_W-1:0] grp_perr,
  input  logic [vard_pkg::CNT_W-1:0] grp_resync,
  output logic                       full,
  output logic                       empty,
  input  logic                       pop,
  output logic [vard_pkg::KIND_W-1:0] out_kind,
  output logic [FRAME_ADDR_BITS-1:0] out_addr,
  output logic [7:0]                 out_data,
  output logic                       out_field,
  output logic [vard_pkg::CNT_W-1:0] out_perr,
  output logic [vard_pkg::CNT_W-1:0] out_resync,
  output logic                       out_last
);
  import vard_pkg::*;

  localparam int DEPTH = 4;
  localparam int PW = 2;
  localparam int GW = 2 + 3*KIND_W + FRAME_ADDR_BITS + 8 + 1 + 2*CNT_W;

  logic [GW-1:0] mem_r [DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [PW:0]   cnt_r;
  logic [1:0]    sub_r;
  logic [GW-1:0] head;
  logic [1:0]    h_cnt;
  logic [2:0][KIND_W-1:0] h_kind;
  logic          do_pop, grp_done;

  assign head = mem_r[rp_r];
  assign {h_cnt, h_kind, out_addr, out_data, out_field, out_perr, out_resync} = head;
  assign out_kind = h_kind[sub_r];
  assign out_last = (sub_r + 2'd1) == h_cnt;
  assign empty = (cnt_r == '0);
  // two slots kept free for the groups still in the front register
  assign full = cnt_r >= (PW+1)'(DEPTH-2);
  assign do_pop = pop && !empty;
  assign grp_done = do_pop && out_last;

  always_ff @(posedge clk) begin
    if (grp_valid)
      mem_r[wp_r] <= {grp_cnt, grp_kind, grp_addr, grp_data, grp_field, grp_perr, grp_resync};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0; sub_r <= '0;
    end else begin
      if (grp_valid) wp_r <= wp_r + 1'b1;
      if (grp_done) begin
        rp_r <= rp_r + 1'b1;
        sub_r <= '0;
      end else if (do_pop) begin
        sub_r <= sub_r + 2'd1;
      end
      cnt_r <= cnt_r + (PW+1)'(grp_valid) - (PW+1)'(grp_done);
    end
  end

endmodule

// ===== rtl/video_audio_record_deframer_core.sv =====
// latency: a result beat reaches the result ports through the front group register and the queue
// throughput: one byte per cycle while full is low; a byte that causes several results holds
// the result side for one pop per result, the group queue absorbs the rest
// reset: synchronous active-low rst_n restores the config, parser and queue control registers and empties the queue
// ----------------------------------------------------------------------------
// video_audio_record_deframer_core
// stream record deframer: audio records, line markers and video writes
// ----------------------------------------------------------------------------
module video_audio_record_deframer_core #(
  parameter int FRAME_ADDR_BITS = vard_pkg::FRAME_ADDR_BITS_DEF,
  parameter int LINE_BYTES_BITS = vard_pkg::LINE_BYTES_BITS_DEF,
  parameter int LINE_COUNT_BITS = vard_pkg::LINE_COUNT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  output logic                          full,
  input  logic [7:0]                    in_stream_byte,
  input  logic                          in_packet_last,
  output logic                          empty,
  input  logic                          pop,
  output logic [vard_pkg::KIND_W-1:0]   out_kind,
  output logic [FRAME_ADDR_BITS-1:0]    out_write_address,
  output logic [7:0]                    out_data_byte,
  output logic                          out_current_field,
  output logic [vard_pkg::CNT_W-1:0]    out_parity_errors,
  output logic [vard_pkg::CNT_W-1:0]    out_resync_count,
  output logic                          out_last,
  input  logic                          cfg_we,
  input  logic [vard_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [vard_pkg::CFG_DATA_W-1:0] cfg_data
);
  import vard_pkg::*;

  logic [LINE_BYTES_BITS-1:0] len_r;
  logic [LINE_BYTES_BITS:0]   stride_r;
  logic [LINE_COUNT_BITS-1:0] height_r;
  logic [FRAME_ADDR_BITS-1:0] fsize_r;
  logic                       inter_r, halt_r;

  logic                       g_valid, g_field, acc;
  logic [1:0]                 g_cnt;
  logic [2:0][KIND_W-1:0]     g_kind;
  logic [FRAME_ADDR_BITS-1:0] g_addr;
  logic [7:0]                 g_data;
  logic [CNT_W-1:0]           g_perr, g_rsy;
  logic [63:0]                cfg_wide;

  assign cfg_wide = 64'(cfg_data);
  assign acc = push && !full && !halt_r && (in_packet_last || !in_packet_last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r    <= (LINE_BYTES_BITS)'(3840);
      stride_r <= (LINE_BYTES_BITS+1)'(3840);
      height_r <= (LINE_COUNT_BITS)'(1080);
      fsize_r  <= (FRAME_ADDR_BITS)'(4147200);
      inter_r  <= 1'b0;
      halt_r   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LINE_LEN:   len_r    <= cfg_wide[LINE_BYTES_BITS-1:0];
        REG_STRIDE:     stride_r <= cfg_wide[LINE_BYTES_BITS:0];
        REG_HEIGHT:     height_r <= cfg_wide[LINE_COUNT_BITS-1:0];
        REG_FRAME_SIZE: fsize_r  <= cfg_wide[FRAME_ADDR_BITS-1:0];
        REG_INTERLACE:  inter_r  <= cfg_data[0];
        REG_HALTED:     halt_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  vard_front #(
    .FRAME_ADDR_BITS(FRAME_ADDR_BITS),
    .LINE_BYTES_BITS(LINE_BYTES_BITS),
    .LINE_COUNT_BITS(LINE_COUNT_BITS)
  ) u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(acc), .in_byte(in_stream_byte),
    .line_len(len_r), .stride(stride_r), .height(height_r), .size_lim(fsize_r),
    .interlaced(inter_r), .grp_valid(g_valid), .grp_cnt(g_cnt), .grp_kind(g_kind),
    .grp_addr(g_addr), .grp_data(g_data), .grp_field(g_field), .grp_perr(g_perr),
    .grp_resync(g_rsy)
  );

  vard_back #(.FRAME_ADDR_BITS(FRAME_ADDR_BITS)) u_back (
    .clk(clk), .rst_n(rst_n), .grp_valid(g_valid), .grp_cnt(g_cnt), .grp_kind(g_kind),
    .grp_addr(g_addr), .grp_data(g_data), .grp_field(g_field), .grp_perr(g_perr),
    .grp_resync(g_rsy), .full(full), .empty(empty), .pop(pop), .out_kind(out_kind),
    .out_addr(out_write_address), .out_data(out_data_byte), .out_field(out_current_field),
    .out_perr(out_parity_errors), .out_resync(out_resync_count), .out_last(out_last)
  );

endmodule

// ===== dv/tb_video_audio_record_deframer_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_video_audio_record_deframer_core
// Self-checking bench for the record deframer. It pushes stream bytes and
// predicts each beat of the result queue: audio bytes, video writes, frame
// events and counters. It sweeps the registers and stalls both queue sides
// at random.
// ----------------------------------------------------------------------------
module tb_video_audio_record_deframer_core;
  import vard_pkg::*;

  typedef struct packed {
    logic [7:0] sbyte;
    logic       plast;
  } in_beat_t;

  typedef struct packed {
    kind_t       kind;
    logic [24:0] addr;
    logic [7:0]  data;
    logic        field;
    logic [15:0] perr;
    logic [15:0] rsync;
    logic        lst;
  } res_beat_t;

  logic clk, rst_n;
  logic push, full, empty, pop;
  logic [7:0] in_stream_byte;
  logic in_packet_last;
  logic [KIND_W-1:0] out_kind;
  logic [24:0] out_write_address;
  logic [7:0] out_data_byte;
  logic out_current_field;
  logic [CNT_W-1:0] out_parity_errors, out_resync_count;
  logic out_last;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  video_audio_record_deframer_core u_top (.*);

  in_beat_t  byte_q[$];
  res_beat_t result_q[$];
  int errors = 0;
  int n_items = 0;
  bit tx_idle_on = 0, rx_idle_on = 0, rx_hold = 0, hold_go = 0;

  // register copies
  logic [13:0] c_len = 14'd3840;
  logic [14:0] c_stride = 15'd3840;
  logic [11:0] c_height = 12'd1080;
  logic [24:0] c_size = 25'd4147200;
  logic c_inter = 0, c_halted = 0;

  // parser copy
  parse_t      stage = ST_HDR;
  logic [23:0] hdr = '0;
  logic [1:0]  hcnt = '0;
  logic [13:0] remain = '0, loff = '0;
  logic [24:0] lbase = '0;
  logic [11:0] lines = '0;
  logic blanking = 1, fbit = 0, started = 0, clr_pend = 1;
  logic [15:0] perr_tot = '0, rsync_tot = '0;
  res_beat_t beats[3];
  int nb;

  always begin
    clk = 1; #4;
    clk = 0; #4;
  end

  function automatic logic [7:0] timing_code(logic f, logic v, logic h);
    return {1'b1, f, v, h, v ^ h, f ^ h, f ^ v, f ^ v ^ h};
  endfunction

  function void add_beat(kind_t k, logic [24:0] a, logic [7:0] d);
    if (nb < 3) begin
      beats[nb] = '{k, a, d, 1'b0, 16'd0, 16'd0, 1'b0};
      nb++;
    end
  endfunction

  function void frame_abort();
    add_beat(K_ABORT, '0, '0);
    clr_pend = 1;
  endfunction

  function void take_marker(logic [7:0] xy);
    logic v, f;
    v = xy[5];
    f = xy[6];
    if (xy != timing_code(f, v, xy[4]) && perr_tot != 16'hffff) perr_tot++;
    if (!v && blanking) begin
      blanking = 0;
      fbit = f;
      if (!c_inter || !f) begin
        if (started) frame_abort();
        add_beat(K_START, '0, '0);
        if (c_inter && clr_pend) begin
          add_beat(K_CLEAR, '0, '0);
          clr_pend = 0;
        end
        lines = '0;
        started = 1;
      end
      lbase = (c_inter && f) ? 25'(c_len) : '0;
    end else if (v && !blanking) begin
      blanking = 1;
      if (started && lines == c_height) add_beat(K_FINISH, '0, '0);
      else if (started && (!c_inter || f)) frame_abort();
    end
  endfunction

  function void deframe_byte(logic [7:0] b);
    logic [25:0] sum;
    nb = 0;
    if (c_halted) return;
    case (stage)
      ST_HDR: begin
        if (hcnt < 3) begin
          hdr = {hdr[15:0], b};
          hcnt++;
        end else begin
          hcnt = 0;
          if (hdr[23:16] != BYTE_SYNC || hdr[15:8] != BYTE_ZERO ||
              (hdr[7:0] != BYTE_SYNC && hdr[7:0] != BYTE_ZERO)) begin
            if (rsync_tot != 16'hffff) rsync_tot++;
          end else begin
            if (hdr[7:0] == BYTE_SYNC) begin
              remain = 14'(b) << 2;
              stage = ST_AUDIO;
            end else begin
              take_marker(b);
              remain = c_len;
              loff = '0;
              stage = b[5] ? ST_SKIP : ST_LINE;
            end
            if (remain == 0) stage = ST_HDR;
          end
        end
      end
      ST_LINE: begin
        sum = 26'(lbase) + 26'(loff);
        if (sum < 26'(c_size)) add_beat(K_VIDEO, sum[24:0], b);
        loff = loff + 1;
        remain--;
        if (remain == 0) begin
          sum = 26'(lbase) + 26'(c_stride);
          lbase = sum[25] ? 25'h1ffffff : sum[24:0];
          if (lines != 12'hfff) lines++;
          stage = ST_HDR;
        end
      end
      ST_AUDIO: begin
        add_beat(K_AUDIO, '0, b);
        remain--;
        if (remain == 0) stage = ST_HDR;
      end
      default: begin
        remain--;
        if (remain == 0) stage = ST_HDR;
      end
    endcase
    for (int k = 0; k < nb; k++) begin
      beats[k].field = fbit;
      beats[k].perr = perr_tot;
      beats[k].rsync = rsync_tot;
      beats[k].lst = (k == nb - 1);
      result_q.push_back(beats[k]);
    end
  endfunction

  task report_mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      push <= 0;
    end else begin
      if (push && !full) deframe_byte(in_stream_byte);
      if (!(push && full)) begin
        if (byte_q.size() > 0 && !(tx_idle_on && $urandom_range(99) < 32)) begin
          in_beat_t nxt;
          nxt = byte_q.pop_front();
          push <= 1;
          in_stream_byte <= nxt.sbyte;
          in_packet_last <= nxt.plast;
        end else begin
          push <= 0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && pop && !empty) begin
      if (result_q.size() == 0) begin
        report_mismatch("unexpected beat kind", out_kind, 0);
      end else begin
        res_beat_t w;
        w = result_q.pop_front();
        if (out_kind != w.kind) report_mismatch("kind", out_kind, w.kind);
        if (out_write_address != w.addr) report_mismatch("address", out_write_address, w.addr);
        if (out_data_byte != w.data) report_mismatch("data", out_data_byte, w.data);
        if (out_current_field != w.field) report_mismatch("field", out_current_field, w.field);
        if (out_parity_errors != w.perr) report_mismatch("parity", out_parity_errors, w.perr);
        if (out_resync_count != w.rsync) report_mismatch("resync", out_resync_count, w.rsync);
        if (out_last != w.lst) report_mismatch("last", out_last, w.lst);
      end
    end
    pop <= rst_n && !rx_hold && !(rx_idle_on && $urandom_range(99) < 32);
  end

  // receiver hold-off so the block backs up
  initial begin
    wait (hold_go);
    rx_hold = 1;
    repeat (600) @(posedge clk);
    rx_hold = 0;
  end

  initial begin
    #1000000;
    $display("status: fail");
    $finish;
  end

  task add_byte(input logic [7:0] b);
    byte_q.push_back('{b, 1'($urandom_range(1))});
    n_items++;
  endtask

  task add_marker(input logic [7:0] xy);
    add_byte(BYTE_SYNC); add_byte(BYTE_ZERO); add_byte(BYTE_ZERO); add_byte(xy);
    for (int i = 0; i < c_len; i++) add_byte(8'($urandom));
  endtask

  task add_audio(input logic [7:0] n);
    add_byte(BYTE_SYNC); add_byte(BYTE_ZERO); add_byte(BYTE_SYNC); add_byte(n);
    for (int i = 0; i < 4 * n; i++) add_byte(8'($urandom));
  endtask

  task add_junk();
    add_byte(8'($urandom)); add_byte(8'($urandom));
    add_byte(8'($urandom)); add_byte(8'($urandom));
  endtask

  function automatic logic [7:0] rand_code(logic f, logic v);
    logic [7:0] x;
    x = timing_code(f, v, 1'($urandom_range(1)));
    if ($urandom_range(9) == 0) x = x ^ (8'd1 << $urandom_range(7));
    return x;
  endfunction

  // blanking, some active lines, blanking again
  task add_field(input logic f);
    int n;
    n = int'(c_height) + $urandom_range(2) - 1;
    if (n < 0) n = 0;
    add_marker(rand_code(f, 1));
    for (int i = 0; i < n; i++) begin
      add_marker(rand_code(f, 0));
      if ($urandom_range(7) == 0) add_audio(8'($urandom_range(3)));
      if ($urandom_range(15) == 0) add_junk();
    end
    add_marker(rand_code(f, 1));
  endtask

  task drain();
    while (byte_q.size() > 0 || push || result_q.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_LINE_LEN:   c_len = val[13:0];
      REG_STRIDE:     c_stride = val[14:0];
      REG_HEIGHT:     c_height = val[11:0];
      REG_FRAME_SIZE: c_size = val[24:0];
      REG_INTERLACE:  c_inter = val[0];
      default:        c_halted = val[0];
    endcase
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task setup(input int len, input int stride, input int height, input int size,
             input bit inter);
    write_reg(REG_LINE_LEN, CFG_DATA_W'(len));
    write_reg(REG_STRIDE, CFG_DATA_W'(stride));
    write_reg(REG_HEIGHT, CFG_DATA_W'(height));
    write_reg(REG_FRAME_SIZE, CFG_DATA_W'(size));
    write_reg(REG_INTERLACE, CFG_DATA_W'(inter));
  endtask

  initial begin
    int start_n;
    rst_n = 0;
    push = 0;
    pop = 0;
    in_stream_byte = '0;
    in_packet_last = 0;
    cfg_we = 0;
    cfg_index = REG_LINE_LEN;
    cfg_data = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: progressive frames, audio, bad headers, extreme bytes
    setup(2, 4, 2, 25'h1ffffff, 0);
    write_reg(REG_HALTED, '0);
    add_audio(8'd2);
    add_audio(8'd0);
    add_byte(8'hff); add_byte(8'hff); add_byte(8'h00); add_byte(8'hff);
    add_byte(8'h00); add_byte(8'h00); add_byte(8'h00); add_byte(8'h00);
    add_field(0);
    add_marker(timing_code(0, 0, 0));
    add_marker(timing_code(0, 1, 0));
    add_marker(8'h7f);
    add_marker(8'h00);
    add_marker(timing_code(0, 0, 1));
    drain();
    write_reg(REG_FRAME_SIZE, CFG_DATA_W'(3));
    add_marker(timing_code(0, 0, 0));
    add_marker(timing_code(0, 0, 0));
    add_marker(timing_code(0, 0, 0));
    add_marker(timing_code(0, 1, 0));
    drain();

    // interlaced pairs, aborted field, zero-length lines
    setup(2, 4, 1, 25'h1ffffff, 1);
    add_field(0); add_field(1);
    add_field(1); add_field(0);
    drain();
    setup(0, 0, 0, 0, 0);
    add_marker(timing_code(0, 0, 0)); add_marker(timing_code(1, 1, 0));
    add_marker(timing_code(0, 0, 0)); add_audio(8'd1);
    drain();

    // halted: everything is dropped
    write_reg(REG_HALTED, CFG_DATA_W'(1));
    for (int i = 0; i < 12; i++) add_byte(8'($urandom));
    drain();
    write_reg(REG_HALTED, '0);

    // random phases
    tx_idle_on = 1;
    rx_idle_on = 1;
    for (int ph = 0; ph < 2; ph++) begin
      setup($urandom_range(1, 3), $urandom_range(16384), $urandom_range(2),
            (ph == 1) ? 5 : $urandom_range(33554431), ph[0]);
      start_n = n_items;
      if (ph == 0) begin
        add_audio(8'd4);
        hold_go = 1;
      end
      while (n_items - start_n < 60) begin
        case ($urandom_range(9))
          0, 1, 2, 3, 4: add_field(1'($urandom_range(1)));
          5, 6:          add_audio(8'($urandom_range(4)));
          7:             add_junk();
          8:             add_marker(8'($urandom));
          default:       add_audio(8'(($urandom_range(1) ? 8'hff : 8'h00)) >> 6);
        endcase
      end
      drain();
    end

    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
